### hdl/fgp_pkg.sv
// ----------------------------------------------------------------------------
// fgp_pkg
// Shared types and constants for the monochrome frame buffer glyph plotter.
// ----------------------------------------------------------------------------
package fgp_pkg;

    // Panel geometry. Each store word holds one whole column of PAGES bytes.
    localparam int COLUMNS = 128;
    localparam int PAGES   = 8;
    localparam int ROWS    = PAGES * 8;
    localparam int COL_AW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Command codes.
    localparam logic [2:0] FUNC_PLOT  = 3'd0;
    localparam logic [2:0] FUNC_FILL  = 3'd1;
    localparam logic [2:0] FUNC_GLYPH = 3'd2;
    localparam logic [2:0] FUNC_CLEAR = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // Glyph height in force after reset.
    localparam logic [6:0] PEN_HEIGHT_RESET = 7'd16;

    // Command word.
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic       ink;
        logic [7:0] glyph_byte;
        logic [6:0] glyph_height;
        logic       glyph_start;
        logic [2:0] page;
    } fgp_cmd_t;

    // Response word.
    typedef struct packed {
        logic [7:0] read_data;
        logic       dropped;
    } fgp_rsp_t;

    // Control of the column update unit: inclusive row range and pixel value.
    typedef struct packed {
        logic [7:0] row_lo;
        logic [7:0] row_hi;
        logic       on;
    } fgp_upd_t;

endpackage

### hdl/fgp_store.sv
// ----------------------------------------------------------------------------
// fgp_store
// Column frame store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module fgp_store (
    input  logic                        clk,
    input  logic                        we,
    input  logic [fgp_pkg::COL_AW-1:0]  waddr,
    input  logic [fgp_pkg::ROWS-1:0]    wdata,
    input  logic [fgp_pkg::COL_AW-1:0]  raddr,
    output logic [fgp_pkg::ROWS-1:0]    rdata
);

    logic [fgp_pkg::ROWS-1:0] mem [fgp_pkg::COLUMNS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### hdl/fgp_update.sv
// ----------------------------------------------------------------------------
// fgp_update
// Shared column update unit: forces a range of rows in one column word.
// ----------------------------------------------------------------------------
module fgp_update (
    input  logic [fgp_pkg::ROWS-1:0] word_in,
    input  fgp_pkg::fgp_upd_t        ctrl,
    output logic [fgp_pkg::ROWS-1:0] word_out
);

    // Row r sits at bit ROWS-1-r of the column word, so each bit compares
    // its own fixed row number against the range.
    always_comb
    begin
        logic [7:0] row_v;
        row_v = '0;
        for (int i = 0; i < fgp_pkg::ROWS; i++)
        begin
            row_v = 8'(fgp_pkg::ROWS - 1 - i);
            if ((ctrl.row_lo <= row_v) && (row_v <= ctrl.row_hi))
            begin
                word_out[i] = ctrl.on;
            end
            else
            begin
                word_out[i] = word_in[i];
            end
        end
    end

endmodule

### hdl/mono_framebuffer_glyph_plotter.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_glyph_plotter
// Page-organized monochrome frame store with point plot, rectangle fill,
// glyph byte unpacking, store clear and byte read back.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Word
//   cmd      in         cmd_valid / cmd_ready  fgp_cmd_t
//   rsp      out        rsp_valid / rsp_ready  fgp_rsp_t
//
// A plot or read goes through accept, store read, modify or capture, and
// finish; one that lands off the panel skips the store. A fill does the
// read-modify-write of one column word in the store for each clipped column,
// between the accept and finish steps. A glyph byte goes through the accept,
// a read of the column word when the pen column is on the panel, one step per
// bit through the shared update unit until the byte or the glyph column ends,
// one write and the finish. A clear zeroes the store one column word per
// cycle; after reset the same sweep zeroes the store while cmd_ready is low.
// A new command is taken while a response still waits in the output register;
// a stalled response holds the sequencer at the end of the next command.
module mono_framebuffer_glyph_plotter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  fgp_pkg::fgp_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output fgp_pkg::fgp_rsp_t rsp
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_RDWAIT = 7'b0001000,
        S_GLYPH  = 7'b0010000,
        S_GWRITE = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t                       state_reg, state_next;
    fgp_pkg::fgp_cmd_t            cmd_reg, cmd_next;
    logic [fgp_pkg::COL_AW-1:0]   col_reg, col_next;
    logic [fgp_pkg::COL_AW-1:0]   lim_x_reg, lim_x_next;
    logic [7:0]                   lim_y_reg, lim_y_next;
    logic                         clear_cmd_reg, clear_cmd_next;
    logic                         gcol_off_reg, gcol_off_next;
    logic [7:0]                   gbits_reg, gbits_next;
    logic [2:0]                   bitcnt_reg, bitcnt_next;
    logic [fgp_pkg::ROWS-1:0]     word_reg, word_next;
    logic                         drop_reg, drop_next;
    logic [7:0]                   data_reg, data_next;
    logic [7:0]                   pen_x_reg, pen_x_next;
    logic [7:0]                   pen_y_reg, pen_y_next;
    logic [7:0]                   origin_y_reg, origin_y_next;
    logic [6:0]                   pen_height_reg, pen_height_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    fgp_pkg::fgp_rsp_t            rsp_reg, rsp_next;

    logic                         st_we;
    logic [fgp_pkg::COL_AW-1:0]   st_waddr;
    logic [fgp_pkg::ROWS-1:0]     st_wdata;
    logic [fgp_pkg::ROWS-1:0]     st_rdata;
    logic [fgp_pkg::ROWS-1:0]     upd_in;
    logic [fgp_pkg::ROWS-1:0]     upd_out;
    fgp_pkg::fgp_upd_t            upd_ctrl;
    logic [7:0]                   rd_byte;

    fgp_store u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (col_reg),
        .rdata (st_rdata)
    );

    fgp_update u_update (
        .word_in  (upd_in),
        .ctrl     (upd_ctrl),
        .word_out (upd_out)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Select the addressed byte of the column word just read.
    always_comb
    begin
        rd_byte = '0;
        for (int p = 0; p < fgp_pkg::PAGES; p++)
        begin
            if (cmd_reg.page == 3'(p))
            begin
                rd_byte = st_rdata[p*8 +: 8];
            end
        end
    end

    // Operands of the shared update unit for the current step.
    always_comb
    begin
        upd_in          = (state_reg == S_RDWAIT) ? st_rdata : word_reg;
        upd_ctrl.row_lo = cmd_reg.y;
        upd_ctrl.row_hi = cmd_reg.y;
        upd_ctrl.on     = cmd_reg.ink;
        if (cmd_reg.func == fgp_pkg::FUNC_FILL)
        begin
            upd_ctrl.row_hi = lim_y_reg;
        end
        else if (cmd_reg.func == fgp_pkg::FUNC_GLYPH)
        begin
            upd_ctrl.row_lo = pen_y_reg;
            upd_ctrl.row_hi = pen_y_reg;
            upd_ctrl.on     = gbits_reg[7] ? cmd_reg.ink : ~cmd_reg.ink;
        end
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        logic [7:0] px;
        logic [7:0] py1;
        logic       x_off;

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        col_next        = col_reg;
        lim_x_next      = lim_x_reg;
        lim_y_next      = lim_y_reg;
        clear_cmd_next  = clear_cmd_reg;
        gcol_off_next   = gcol_off_reg;
        gbits_next      = gbits_reg;
        bitcnt_next     = bitcnt_reg;
        word_next       = word_reg;
        drop_next       = drop_reg;
        data_next       = data_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        origin_y_next   = origin_y_reg;
        pen_height_next = pen_height_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        st_we           = 1'b0;
        st_waddr        = col_reg;
        st_wdata        = upd_out;
        px              = pen_x_reg;
        py1             = pen_y_reg + 8'd1;
        x_off           = ({1'b0, cmd.x} >= 9'(fgp_pkg::COLUMNS));

        // The consumer takes the waiting response.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            // Zero the store one column per cycle.
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_wdata = '0;
                if (col_reg == fgp_pkg::COL_AW'(fgp_pkg::COLUMNS - 1))
                begin
                    col_next   = '0;
                    state_next = clear_cmd_reg ? S_FINISH : S_IDLE;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end

            // Take a command and decide which steps it needs.
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next       = cmd;
                    drop_next      = 1'b0;
                    data_next      = '0;
                    clear_cmd_next = 1'b0;
                    col_next       = cmd.x[fgp_pkg::COL_AW-1:0];
                    state_next     = S_FINISH;
                    priority case (cmd.func)
                        fgp_pkg::FUNC_PLOT:
                        begin
                            if (x_off || (cmd.y >= 8'(fgp_pkg::ROWS)))
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        fgp_pkg::FUNC_FILL:
                        begin
                            lim_x_next = ({1'b0, cmd.x_end} >= 9'(fgp_pkg::COLUMNS))
                                       ? fgp_pkg::COL_AW'(fgp_pkg::COLUMNS - 1)
                                       : cmd.x_end[fgp_pkg::COL_AW-1:0];
                            lim_y_next = (cmd.y_end >= 8'(fgp_pkg::ROWS))
                                       ? 8'(fgp_pkg::ROWS - 1) : cmd.y_end;
                            if ((cmd.x <= cmd.x_end) && (cmd.y <= cmd.y_end))
                            begin
                                drop_next =
                                    ({1'b0, cmd.x_end} >= 9'(fgp_pkg::COLUMNS)) ||
                                    (cmd.y_end >= 8'(fgp_pkg::ROWS));
                                if (!x_off)
                                begin
                                    state_next = S_READ;
                                end
                            end
                        end
                        fgp_pkg::FUNC_GLYPH:
                        begin
                            if (cmd.glyph_start)
                            begin
                                px              = cmd.x;
                                pen_x_next      = cmd.x;
                                pen_y_next      = cmd.y;
                                origin_y_next   = cmd.y;
                                pen_height_next = cmd.glyph_height;
                            end
                            gcol_off_next = ({1'b0, px} >= 9'(fgp_pkg::COLUMNS));
                            col_next      = px[fgp_pkg::COL_AW-1:0];
                            gbits_next    = cmd.glyph_byte;
                            bitcnt_next   = '0;
                            if ({1'b0, px} >= 9'(fgp_pkg::COLUMNS))
                            begin
                                state_next = S_GLYPH;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        fgp_pkg::FUNC_CLEAR:
                        begin
                            col_next       = '0;
                            clear_cmd_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        fgp_pkg::FUNC_READ:
                        begin
                            if (x_off || ({1'b0, cmd.page} >= 4'(fgp_pkg::PAGES)))
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // The store address is col_reg; data arrives next cycle.
            S_READ:
            begin
                state_next = S_RDWAIT;
            end

            // Column word is valid: modify and write back, or capture it.
            S_RDWAIT:
            begin
                state_next = S_FINISH;
                priority case (cmd_reg.func)
                    fgp_pkg::FUNC_PLOT:
                    begin
                        st_we = 1'b1;
                    end
                    fgp_pkg::FUNC_FILL:
                    begin
                        st_we = 1'b1;
                        if (col_reg != lim_x_reg)
                        begin
                            col_next   = col_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    fgp_pkg::FUNC_GLYPH:
                    begin
                        word_next  = st_rdata;
                        state_next = S_GLYPH;
                    end
                    fgp_pkg::FUNC_READ:
                    begin
                        data_next = rd_byte;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // One glyph bit per cycle down the pen column.
            S_GLYPH:
            begin
                word_next   = upd_out;
                gbits_next  = {gbits_reg[6:0], 1'b0};
                bitcnt_next = bitcnt_reg + 3'd1;
                if (gcol_off_reg || (pen_y_reg >= 8'(fgp_pkg::ROWS)))
                begin
                    drop_next = 1'b1;
                end
                if ((py1 - origin_y_reg) == {1'b0, pen_height_reg})
                begin
                    pen_y_next = origin_y_reg;
                    pen_x_next = pen_x_reg + 8'd1;
                    state_next = S_GWRITE;
                end
                else
                begin
                    pen_y_next = py1;
                    if (bitcnt_reg == 3'd7)
                    begin
                        state_next = S_GWRITE;
                    end
                end
            end

            // Write the finished glyph column back if it is on the panel.
            S_GWRITE:
            begin
                st_wdata   = word_reg;
                st_we      = !gcol_off_reg;
                state_next = S_FINISH;
            end

            // Hand the response to the output register once it is free.
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.read_data = data_reg;
                    rsp_next.dropped   = drop_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and pen state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            col_reg        <= '0;
            clear_cmd_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            origin_y_reg   <= '0;
            pen_height_reg <= fgp_pkg::PEN_HEIGHT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            clear_cmd_reg  <= clear_cmd_next;
            rsp_valid_reg  <= rsp_valid_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            origin_y_reg   <= origin_y_next;
            pen_height_reg <= pen_height_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        lim_x_reg    <= lim_x_next;
        lim_y_reg    <= lim_y_next;
        gcol_off_reg <= gcol_off_next;
        gbits_reg    <= gbits_next;
        bitcnt_reg   <= bitcnt_next;
        word_reg     <= word_next;
        drop_reg     <= drop_next;
        data_reg     <= data_next;
        rsp_reg      <= rsp_next;
    end

`ifndef SYNTHESIS
    // The store is never written while waiting for a command.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !st_we)
        else $error("store written while idle");

    // A command holds off the next one: cmd_ready is low in the cycle after it.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command accepted back to back");

    // A new response only ever comes out of the finish step.
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("response loaded outside finish");

    // The fill column walk never passes its clipped last column.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RDWAIT) && (cmd_reg.func == fgp_pkg::FUNC_FILL))
        |-> (col_reg <= lim_x_reg))
        else $error("fill column beyond limit");
`endif

endmodule

### tb/sv/mono_framebuffer_glyph_plotter_tb.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_glyph_plotter_tb
// Self-checking bench for the page-organized monochrome frame store. A
// behavioral mirror of the store and the glyph pen predicts each response.
// Directed corner cases come first, then random traffic made mostly of glyph
// runs, plots, small fills and read backs. Traffic runs under several idle and
// stall patterns, a long response hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module mono_framebuffer_glyph_plotter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int PHASE_WORDS    = 420;

    // Command codes that the block treats as no-ops.
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    fgp_pkg::fgp_cmd_t  cmd       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    fgp_pkg::fgp_rsp_t  rsp;

    // Mirror of the frame store and the glyph pen.
    logic [7:0] frame_mirror [fgp_pkg::COLUMNS * fgp_pkg::PAGES];
    logic [7:0] pen_col;
    logic [7:0] pen_row;
    logic [7:0] origin_row;
    logic [6:0] glyph_rows;

    fgp_pkg::fgp_rsp_t pending_rsp_q [$];
    fgp_pkg::fgp_rsp_t expected_rsp;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int words_sent     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    mono_framebuffer_glyph_plotter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Free-running clock.
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void blank_mirror();
        foreach (frame_mirror[i])
            frame_mirror[i] = '0;
    endfunction

    // Sets or clears one pixel; returns 1 when the point lies off the panel.
    function automatic bit mirror_pixel(int col, int row, bit on);
        int         idx;
        logic [7:0] mask;
        if (col >= fgp_pkg::COLUMNS || row >= fgp_pkg::ROWS)
            return 1'b1;
        idx  = col * fgp_pkg::PAGES + (fgp_pkg::PAGES - 1) - row / 8;
        mask = 8'h80 >> (row % 8);
        if (on)
            frame_mirror[idx] = frame_mirror[idx] | mask;
        else
            frame_mirror[idx] = frame_mirror[idx] & ~mask;
        return 1'b0;
    endfunction

    // Applies one command to the mirror and returns the response it yields.
    function automatic fgp_pkg::fgp_rsp_t predict_plot_rsp(fgp_pkg::fgp_cmd_t c);
        fgp_pkg::fgp_rsp_t r;
        int                col_last;
        int                row_last;
        bit                pix_on;
        bit                column_done;
        r = '0;
        case (c.func)
            fgp_pkg::FUNC_PLOT:
            begin
                r.dropped = mirror_pixel(c.x, c.y, c.ink);
            end
            fgp_pkg::FUNC_FILL:
            begin
                // An inverted range draws nothing; the range is clipped to the panel.
                if (c.x <= c.x_end && c.y <= c.y_end)
                begin
                    col_last  = (c.x_end < fgp_pkg::COLUMNS) ? int'(c.x_end)
                                                             : fgp_pkg::COLUMNS - 1;
                    row_last  = (c.y_end < fgp_pkg::ROWS) ? int'(c.y_end)
                                                          : fgp_pkg::ROWS - 1;
                    r.dropped = (c.x_end >= fgp_pkg::COLUMNS) ||
                                (c.y_end >= fgp_pkg::ROWS);
                    for (int cx = c.x; cx <= col_last; cx++)
                        for (int cy = c.y; cy <= row_last; cy++)
                            void'(mirror_pixel(cx, cy, c.ink));
                end
            end
            fgp_pkg::FUNC_GLYPH:
            begin
                if (c.glyph_start)
                begin
                    pen_col    = c.x;
                    pen_row    = c.y;
                    origin_row = c.y;
                    glyph_rows = c.glyph_height;
                end
                // Bits go MSB first down the column; the rest of the byte is
                // dropped once the column reaches the glyph height.
                column_done = 1'b0;
                for (int b = 7; b >= 0 && !column_done; b--)
                begin
                    pix_on = c.glyph_byte[b] ? c.ink : !c.ink;
                    if (mirror_pixel(pen_col, pen_row, pix_on))
                        r.dropped = 1'b1;
                    pen_row = pen_row + 8'd1;
                    if (8'(pen_row - origin_row) == {1'b0, glyph_rows})
                    begin
                        pen_row     = origin_row;
                        pen_col     = pen_col + 8'd1;
                        column_done = 1'b1;
                    end
                end
            end
            fgp_pkg::FUNC_CLEAR:
            begin
                blank_mirror();
            end
            fgp_pkg::FUNC_READ:
            begin
                if (c.x < fgp_pkg::COLUMNS && c.page < fgp_pkg::PAGES)
                    r.read_data = frame_mirror[c.x * fgp_pkg::PAGES + c.page];
                else
                    r.dropped = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // A command word with every field random except the function code.
    function automatic fgp_pkg::fgp_cmd_t random_cmd(logic [2:0] func);
        fgp_pkg::fgp_cmd_t c;
        c.func         = func;
        c.x            = 8'($urandom);
        c.y            = 8'($urandom);
        c.x_end        = 8'($urandom);
        c.y_end        = 8'($urandom);
        c.ink          = 1'($urandom);
        c.glyph_byte   = 8'($urandom);
        c.glyph_height = 7'($urandom);
        c.glyph_start  = 1'($urandom);
        c.page         = 3'($urandom);
        return c;
    endfunction

    // Mostly on-panel coordinates, with an occasional one anywhere in range.
    function automatic logic [7:0] pick_col();
        if ($urandom_range(7) == 0)
            return 8'($urandom);
        return 8'($urandom_range(fgp_pkg::COLUMNS - 1));
    endfunction

    function automatic logic [7:0] pick_row();
        if ($urandom_range(7) == 0)
            return 8'($urandom);
        return 8'($urandom_range(fgp_pkg::ROWS - 1));
    endfunction

    // Offers one word and returns at the edge where it is accepted.
    task automatic send_word(fgp_pkg::fgp_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        pending_rsp_q.push_back(predict_plot_rsp(c));
        words_sent++;
    endtask

    task automatic send_plot(logic [7:0] x, logic [7:0] y, logic ink);
        fgp_pkg::fgp_cmd_t c;
        c     = random_cmd(fgp_pkg::FUNC_PLOT);
        c.x   = x;
        c.y   = y;
        c.ink = ink;
        send_word(c);
    endtask

    task automatic send_fill(logic [7:0] x, logic [7:0] y, logic [7:0] x_end,
                             logic [7:0] y_end, logic ink);
        fgp_pkg::fgp_cmd_t c;
        c       = random_cmd(fgp_pkg::FUNC_FILL);
        c.x     = x;
        c.y     = y;
        c.x_end = x_end;
        c.y_end = y_end;
        c.ink   = ink;
        send_word(c);
    endtask

    task automatic send_glyph(logic start, logic [7:0] x, logic [7:0] y,
                              logic [6:0] height, logic [7:0] bits, logic ink);
        fgp_pkg::fgp_cmd_t c;
        c              = random_cmd(fgp_pkg::FUNC_GLYPH);
        c.glyph_start  = start;
        c.x            = x;
        c.y            = y;
        c.glyph_height = height;
        c.glyph_byte   = bits;
        c.ink          = ink;
        send_word(c);
    endtask

    task automatic send_read(logic [7:0] x, logic [2:0] page);
        fgp_pkg::fgp_cmd_t c;
        c      = random_cmd(fgp_pkg::FUNC_READ);
        c.x    = x;
        c.page = page;
        send_word(c);
    endtask

    // Drops valid and waits until every expected response has arrived.
    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // One random command, or a whole glyph run of several bytes.
    task automatic send_random_burst();
        int         pick;
        logic [6:0] height;
        logic [7:0] x;
        logic [7:0] y;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            send_plot(pick_col(), pick_row(), 1'($urandom));
        end
        else if (pick < 40)
        begin
            // Mostly small fills; a few with fully random corners.
            if ($urandom_range(9) == 0)
            begin
                send_word(random_cmd(fgp_pkg::FUNC_FILL));
            end
            else
            begin
                x = pick_col();
                y = pick_row();
                send_fill(x, y,
                          8'((int'(x) + $urandom_range(5) > 255)
                             ? 255 : x + $urandom_range(5)),
                          8'((int'(y) + $urandom_range(12) > 255)
                             ? 255 : y + $urandom_range(12)),
                          1'($urandom));
            end
        end
        else if (pick < 70)
        begin
            case ($urandom_range(5))
                0:       height = 7'd8;
                1:       height = 7'd12;
                2:       height = 7'd16;
                3:       height = 7'd22;
                4:       height = 7'd32;
                default: height = 7'($urandom);
            endcase
            send_glyph(1'b1, pick_col(), pick_row(), height, 8'($urandom), 1'($urandom));
            repeat ($urandom_range(12, 1))
                send_glyph(1'($urandom_range(15) == 0), pick_col(), pick_row(),
                           7'($urandom), 8'($urandom), 1'($urandom));
        end
        else if (pick < 73)
        begin
            send_word(random_cmd(fgp_pkg::FUNC_CLEAR));
        end
        else if (pick < 95)
        begin
            send_read(($urandom_range(9) == 0) ? 8'($urandom)
                                               : 8'($urandom_range(fgp_pkg::COLUMNS - 1)),
                      3'($urandom));
        end
        else
        begin
            send_word(random_cmd(3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST))));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Panel corners, off-panel points, empty and clipped fills, glyph wrap
    // cases, clear and the spare codes.
    task automatic test_directed_cases();
        send_plot(8'd0, 8'd0, 1'b1);
        send_plot(8'd127, 8'd63, 1'b1);
        send_plot(8'd128, 8'd0, 1'b1);
        send_plot(8'd0, 8'd64, 1'b1);
        send_plot(8'd255, 8'd255, 1'b0);
        send_read(8'd0, 3'd7);
        send_read(8'd127, 3'd0);
        send_read(8'd128, 3'd0);
        send_fill(8'd10, 8'd0, 8'd5, 8'd10, 1'b1);
        send_fill(8'd0, 8'd20, 8'd10, 8'd19, 1'b1);
        send_fill(8'd120, 8'd56, 8'd255, 8'd255, 1'b1);
        send_read(8'd127, 3'd0);
        send_fill(8'd0, 8'd0, 8'd127, 8'd63, 1'b0);
        send_glyph(1'b1, 8'd5, 8'd3, 7'd12, 8'hA5, 1'b1);
        send_glyph(1'b0, 8'd0, 8'd0, 7'd0, 8'h3C, 1'b0);
        send_glyph(1'b1, 8'd127, 8'd60, 7'd22, 8'hFF, 1'b1);
        // Height zero: the pen row wraps past 255 before the column ends.
        send_glyph(1'b1, 8'd2, 8'd250, 7'd0, 8'h81, 1'b1);
        send_read(8'd5, 3'd7);
        send_word(random_cmd(fgp_pkg::FUNC_CLEAR));
        send_read(8'd5, 3'd7);
        for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
            send_word(random_cmd(3'(f)));
        send_glyph(1'b1, 8'd64, 8'd32, 7'd1, 8'h80, 1'b1);
        send_read(8'd64, 3'd3);
    endtask

    task automatic test_random_mix(int idle_pct, int stall_pct, int count);
        int goal;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal           = words_sent + count;
        while (words_sent < goal)
            send_random_burst();
    endtask

    // Responses are held off for a long stretch while commands keep coming.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        repeat (40)
            send_random_burst();
    endtask

    // The sender stops until the block has answered everything.
    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        repeat (20)
            send_random_burst();
        drain_results();
        repeat (20)
            send_random_burst();
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // Response ready, with random stalls and an optional long hold-off.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted response word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("unexpected response: read_data %0h dropped %0b",
                       rsp.read_data, rsp.dropped);
                mismatch_count++;
            end
            else
            begin
                expected_rsp = pending_rsp_q.pop_front();
                if (rsp.read_data !== expected_rsp.read_data)
                begin
                    $error("read_data: expected %0h, got %0h",
                           expected_rsp.read_data, rsp.read_data);
                    mismatch_count++;
                end
                if (rsp.dropped !== expected_rsp.dropped)
                begin
                    $error("dropped: expected %0b, got %0b",
                           expected_rsp.dropped, rsp.dropped);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when neither channel has moved a word for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        blank_mirror();
        pen_col    = '0;
        pen_row    = '0;
        origin_row = '0;
        glyph_rows = fgp_pkg::PEN_HEIGHT_RESET;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_mix(0, 0, PHASE_WORDS);
        test_output_backpressure();
        test_random_mix(54, 0, PHASE_WORDS);
        test_random_mix(0, 54, PHASE_WORDS);
        test_drain_pause();
        test_random_mix(8, 8, PHASE_WORDS);

        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
hdl/fgp_pkg.sv
hdl/fgp_store.sv
hdl/fgp_update.sv
hdl/mono_framebuffer_glyph_plotter.sv
tb/sv/mono_framebuffer_glyph_plotter_tb.sv
